// ----- sv/clnib_pkg.sv -----
// Package: shared types and constants for the character LCD nibble sequencer.
package clnib_pkg;

   typedef enum logic [1:0] {
      OP_INIT    = 2'd0,
      OP_COMMAND = 2'd1,
      OP_DATA    = 2'd2,
      OP_CURSOR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_FUNCTION_SET = 2'd0,
      CSR_ENTRY_MODE   = 2'd1,
      CSR_DISPLAY_CTRL = 2'd2
   } csr_index_type;

   localparam logic [7:0] FUNCTION_SET_RESET = 8'h28;
   localparam logic [7:0] ENTRY_MODE_RESET   = 8'h06;
   localparam logic [7:0] DISPLAY_CTRL_RESET = 8'h0F;
   localparam logic [7:0] CMD_CLEAR          = 8'h01;
   localparam logic [3:0] NIB_WAKE           = 4'h3;
   localparam logic [3:0] NIB_FOUR_BIT       = 4'h2;
   localparam logic [2:0] WAIT_FIRST_WAKE_MS = 3'd5;
   localparam logic [2:0] WAIT_SHORT_MS      = 3'd1;
   localparam logic [2:0] WAIT_SLOW_CMD_MS   = 3'd2;
   localparam logic [7:0] SLOW_CMD_LIMIT     = 8'd4;

   localparam int         STEP_W             = 4;
   localparam logic [STEP_W-1:0] STEP_LAST_BYTE = 4'd1;
   localparam logic [STEP_W-1:0] STEP_LAST_INIT = 4'd11;
   localparam logic [STEP_W-1:0] STEP_FOUR_BIT  = 4'd3;
   localparam logic [STEP_W-1:0] STEP_FIRST     = 4'd0;

   localparam int         QUEUE_DEPTH        = 2;

   typedef struct packed {
      logic       is_init;
      logic       rs;
      logic [7:0] cmd;
   } job_type;

   typedef struct packed {
      logic [7:0] function_set;
      logic [7:0] entry_mode;
      logic [7:0] display_ctrl;
   } cfg_type;

   typedef struct packed {
      logic [3:0] nibble;
      logic       register_select;
      logic [4:0] wait_before_ms;
      logic [2:0] wait_after_ms;
      logic       last;
   } pulse_type;

endpackage

// ----- sv/clnib_if.sv -----
// Interfaces: request, response and register write channels.
interface clnib_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [7:0] value;
   logic       row;
   logic [5:0] column;
   modport source (output valid, operation, value, row, column, input ready);
   modport sink   (input valid, operation, value, row, column, output ready);
endinterface

interface clnib_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] nibble;
   logic       register_select;
   logic [4:0] wait_before_ms;
   logic [2:0] wait_after_ms;
   logic       last;
   modport source (output valid, nibble, register_select, wait_before_ms, wait_after_ms,
                   last, input ready);
   modport sink   (input valid, nibble, register_select, wait_before_ms, wait_after_ms,
                   last, output ready);
endinterface

interface clnib_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [7:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/clnib_front.sv -----
// Front end: accept requests and turn each into a queued job.
module clnib_front
   import clnib_pkg::*;
(
   clnib_req_if.sink req_chan,
   input  logic      queue_full,
   output logic      push,
   output job_type   job
);

   assign req_chan.ready = !queue_full;
   assign push           = req_chan.valid && !queue_full;

   always_comb begin
      job = '0;
      unique case (op_type'(req_chan.operation))
         OP_INIT: begin
            job.is_init = 1'b1;
         end
         OP_COMMAND: begin
            job.cmd = req_chan.value;
         end
         OP_DATA: begin
            job.rs  = 1'b1;
            job.cmd = req_chan.value;
         end
         OP_CURSOR: begin
            job.cmd = {1'b1, req_chan.row, req_chan.column};
         end
         default: begin
            job = '0;
         end
      endcase
   end

endmodule

// ----- sv/clnib_queue.sv -----
// Job queue: short FIFO between the front end and the pulse sequencer.
module clnib_queue
   import clnib_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    full,
   output logic    not_empty,
   output job_type head
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

   job_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full      = (count_ff == DEPTH_CNT);
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- sv/clnib_back.sv -----
// Back end: step through each job, register one enable pulse per cycle unless stalled.
module clnib_back
   import clnib_pkg::*;
#(
   parameter logic [4:0] POWER_UP_WAIT_MS = 5'd30
) (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      job_valid,
   input  job_type   job,
   output logic      pop,
   clnib_rsp_if.source rsp_chan
);

   logic [STEP_W-1:0] step_ff, step_in;
   logic              out_valid_ff, out_valid_in;
   pulse_type         out_ff;
   pulse_type         pulse;
   logic [7:0]        cmd;
   logic              load;

   always_comb begin
      cmd = job.cmd;
      if (job.is_init) begin
         case (step_ff[2:1])
            2'b10:   cmd = cfg.function_set;
            2'b11:   cmd = cfg.entry_mode;
            2'b00:   cmd = CMD_CLEAR;
            default: cmd = cfg.display_ctrl;
         endcase
      end
   end

   always_comb begin
      pulse                 = '0;
      pulse.register_select = job.rs;
      if (job.is_init && step_ff <= STEP_FOUR_BIT) begin
         pulse.nibble        = (step_ff == STEP_FOUR_BIT) ? NIB_FOUR_BIT : NIB_WAKE;
         pulse.wait_after_ms = (step_ff == STEP_FIRST) ? WAIT_FIRST_WAKE_MS : WAIT_SHORT_MS;
         if (step_ff == STEP_FIRST) begin
            pulse.wait_before_ms = POWER_UP_WAIT_MS;
         end
      end else if (step_ff[0]) begin
         pulse.nibble = cmd[3:0];
         if (job.rs || cmd >= SLOW_CMD_LIMIT) begin
            pulse.wait_after_ms = WAIT_SHORT_MS;
         end else begin
            pulse.wait_after_ms = WAIT_SLOW_CMD_MS;
         end
      end else begin
         pulse.nibble = cmd[7:4];
      end
      pulse.last = job.is_init ? (step_ff == STEP_LAST_INIT) : (step_ff == STEP_LAST_BYTE);
   end

   assign load = job_valid && (!out_valid_ff || rsp_chan.ready);
   assign pop  = load && pulse.last;

   always_comb begin
      step_in      = step_ff;
      out_valid_in = out_valid_ff;
      if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
      if (load) begin
         out_valid_in = 1'b1;
         step_in      = pulse.last ? '0 : step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= pulse;
      end
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.nibble          = out_ff.nibble;
   assign rsp_chan.register_select = out_ff.register_select;
   assign rsp_chan.wait_before_ms  = out_ff.wait_before_ms;
   assign rsp_chan.wait_after_ms   = out_ff.wait_after_ms;
   assign rsp_chan.last            = out_ff.last;

endmodule

// ----- sv/char_lcd_nibble_sequencer_core.sv -----
// Top level: character LCD 4-bit nibble sequencer with its setup registers.
//
// Each request turns into enable pulses for a 4-bit character LCD: init gives
// twelve, a command, data byte or cursor move gives two. The pulse sequencer
// emits one pulse per cycle while the response side keeps ready high, and
// requests are taken into a two-entry job queue while earlier ones are still
// being sent; the response output is registered. The three setup commands
// are written through the register port, which never stalls; write them only
// while no request is in flight.
module char_lcd_nibble_sequencer_core
   import clnib_pkg::*;
#(
   parameter int POWER_UP_WAIT_MS = 30
) (
   input  logic         clock,
   input  logic         reset,
   clnib_req_if.sink    req_chan,
   clnib_rsp_if.source  rsp_chan,
   clnib_csr_if.sink    csr_chan
);

   cfg_type cfg_ff;
   logic    push;
   logic    pop;
   logic    queue_full;
   logic    queue_not_empty;
   job_type push_job;
   job_type head_job;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.function_set <= FUNCTION_SET_RESET;
         cfg_ff.entry_mode   <= ENTRY_MODE_RESET;
         cfg_ff.display_ctrl <= DISPLAY_CTRL_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_FUNCTION_SET: cfg_ff.function_set <= csr_chan.data;
            CSR_ENTRY_MODE:   cfg_ff.entry_mode   <= csr_chan.data;
            CSR_DISPLAY_CTRL: cfg_ff.display_ctrl <= csr_chan.data;
            default:          cfg_ff              <= cfg_ff;
         endcase
      end
   end

   clnib_front u_front (
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .job        (push_job)
   );

   clnib_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head      (head_job)
   );

   clnib_back #(
      .POWER_UP_WAIT_MS (5'(POWER_UP_WAIT_MS))
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_valid (queue_not_empty),
      .job       (head_job),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ----- tb/sv/tb_char_lcd_nibble_sequencer_core.sv -----
// Testbench: drives LCD requests and setup writes, predicts every enable pulse and checks it.
`timescale 1ns / 100ps

module tb_char_lcd_nibble_sequencer_core;
   import clnib_pkg::*;

   localparam int         PWR_WAIT_MS   = 30;
   localparam logic [7:0] LINE0_BASE    = 8'h80;
   localparam logic [7:0] LINE1_BASE    = 8'hC0;
   localparam int         QUIET_LIMIT   = 2000;
   localparam int         HOLD_CYCLES   = 60;
   localparam int         END_CYCLES    = 10;
   localparam int         SEGMENTS      = 7;
   localparam int         SEGMENT_ITEMS = 40;

   class lcd_pulse_book;
      cfg_type   cfg;
      pulse_type pulses_due[$];
      int        mismatches;

      function new();
         cfg.function_set = FUNCTION_SET_RESET;
         cfg.entry_mode   = ENTRY_MODE_RESET;
         cfg.display_ctrl = DISPLAY_CTRL_RESET;
         mismatches       = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [7:0] wdata);
         case (idx)
            CSR_FUNCTION_SET: cfg.function_set = wdata;
            CSR_ENTRY_MODE:   cfg.entry_mode   = wdata;
            CSR_DISPLAY_CTRL: cfg.display_ctrl = wdata;
            default: ;
         endcase
      endfunction

      function void add_pulse(logic [3:0] nib, logic rs, logic [4:0] wait_pre,
                              logic [2:0] wait_post, logic fin);
         pulse_type p;
         p.nibble          = nib;
         p.register_select = rs;
         p.wait_before_ms  = wait_pre;
         p.wait_after_ms   = wait_post;
         p.last            = fin;
         pulses_due.push_back(p);
      endfunction

      function void add_byte(logic [7:0] b, logic rs, logic fin);
         logic [2:0] wait_post;
         if (rs)
            wait_post = WAIT_SHORT_MS;
         else
            wait_post = (b < SLOW_CMD_LIMIT) ? WAIT_SLOW_CMD_MS : WAIT_SHORT_MS;
         add_pulse(b[7:4], rs, 5'd0, 3'd0, 1'b0);
         add_pulse(b[3:0], rs, 5'd0, wait_post, fin);
      endfunction

      function void take_request(op_type op, logic [7:0] value, logic row,
                                 logic [5:0] column);
         case (op)
            OP_INIT: begin
               add_pulse(NIB_WAKE, 1'b0, 5'(PWR_WAIT_MS), WAIT_FIRST_WAKE_MS, 1'b0);
               add_pulse(NIB_WAKE, 1'b0, 5'd0, WAIT_SHORT_MS, 1'b0);
               add_pulse(NIB_WAKE, 1'b0, 5'd0, WAIT_SHORT_MS, 1'b0);
               add_pulse(NIB_FOUR_BIT, 1'b0, 5'd0, WAIT_SHORT_MS, 1'b0);
               add_byte(cfg.function_set, 1'b0, 1'b0);
               add_byte(cfg.entry_mode, 1'b0, 1'b0);
               add_byte(CMD_CLEAR, 1'b0, 1'b0);
               add_byte(cfg.display_ctrl, 1'b0, 1'b1);
            end
            OP_COMMAND: add_byte(value, 1'b0, 1'b1);
            OP_DATA:    add_byte(value, 1'b1, 1'b1);
            default:    add_byte((row ? LINE1_BASE : LINE0_BASE) + {2'b00, column}, 1'b0, 1'b1);
         endcase
      endfunction

      function void match_pulse(pulse_type got);
         pulse_type want;
         if (pulses_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected pulse: nib %h rs %b before %0d after %0d last %b",
                        got.nibble, got.register_select, got.wait_before_ms,
                        got.wait_after_ms, got.last);
            return;
         end
         want = pulses_due.pop_front();
         if (got.nibble !== want.nibble || got.register_select !== want.register_select ||
             got.wait_before_ms !== want.wait_before_ms ||
             got.wait_after_ms !== want.wait_after_ms || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("pulse mismatch: expected nib %h rs %b before %0d after %0d last %b, got nib %h rs %b before %0d after %0d last %b",
                        want.nibble, want.register_select, want.wait_before_ms,
                        want.wait_after_ms, want.last, got.nibble, got.register_select,
                        got.wait_before_ms, got.wait_after_ms, got.last);
         end
      endfunction

      function int pending();
         return pulses_due.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   int   idle_pct;
   bit   hold_request;

   lcd_pulse_book pulse_book;

   clnib_req_if req_bus ();
   clnib_rsp_if rsp_bus ();
   clnib_csr_if csr_bus ();

   char_lcd_nibble_sequencer_core #(
      .POWER_UP_WAIT_MS(PWR_WAIT_MS)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   task automatic send_request(op_type op, logic [7:0] value, logic row, logic [5:0] column);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.operation <= op;
      req_bus.value     <= value;
      req_bus.row       <= row;
      req_bus.column    <= column;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pulse_book.take_request(op, value, row, column);
   endtask

   task automatic send_random_request();
      int         pick;
      op_type     op;
      logic [7:0] value;
      pick = $urandom_range(99);
      if (pick < 10)
         op = OP_INIT;
      else if (pick < 40)
         op = OP_COMMAND;
      else if (pick < 70)
         op = OP_DATA;
      else
         op = OP_CURSOR;
      if ($urandom_range(99) < 15)
         value = 8'($urandom_range(5));
      else
         value = 8'($urandom_range(255));
      send_request(op, value, 1'($urandom_range(1)), 6'($urandom_range(63)));
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (pulse_book.pending() != 0) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [7:0] wdata);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= wdata;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      pulse_book.set_register(idx, wdata);
   endtask

   task automatic set_registers(logic [7:0] fset, logic [7:0] emode, logic [7:0] dctrl);
      write_register(CSR_FUNCTION_SET, fset);
      write_register(CSR_ENTRY_MODE, emode);
      write_register(CSR_DISPLAY_CTRL, dctrl);
      csr_bus.valid <= 1'b0;
   endtask

   initial begin
      int hold_left;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready)
            pulse_book.match_pulse({rsp_bus.nibble, rsp_bus.register_select,
                                    rsp_bus.wait_before_ms, rsp_bus.wait_after_ms,
                                    rsp_bus.last});
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= idle_pct);
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin
      pulse_book   = new();
      idle_pct     = 24;
      hold_request = 1'b0;
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.operation <= OP_INIT;
      req_bus.value     <= 8'h00;
      req_bus.row       <= 1'b0;
      req_bus.column    <= 6'd0;
      csr_bus.valid     <= 1'b0;
      csr_bus.index     <= CSR_FUNCTION_SET;
      csr_bus.data      <= 8'h00;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_request(OP_INIT, 8'h00, 1'b0, 6'd0);
      send_request(OP_COMMAND, 8'h00, 1'b0, 6'd0);
      send_request(OP_COMMAND, 8'h03, 1'b1, 6'd63);
      send_request(OP_COMMAND, 8'h04, 1'b0, 6'd0);
      send_request(OP_COMMAND, 8'hFF, 1'b1, 6'd63);
      send_request(OP_DATA, 8'h00, 1'b1, 6'd63);
      send_request(OP_DATA, 8'hFF, 1'b0, 6'd0);
      send_request(OP_DATA, 8'h02, 1'b0, 6'd21);
      send_request(OP_DATA, 8'hA5, 1'b1, 6'd42);
      send_request(OP_CURSOR, 8'hFF, 1'b0, 6'd0);
      send_request(OP_CURSOR, 8'h00, 1'b0, 6'd63);
      send_request(OP_CURSOR, 8'hFF, 1'b1, 6'd0);
      send_request(OP_CURSOR, 8'h00, 1'b1, 6'd63);
      send_request(OP_INIT, 8'hFF, 1'b1, 6'd63);

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         drain();
         if (seg == 0)
            set_registers(8'h00, 8'h00, 8'h00);
         else if (seg == 1)
            set_registers(8'hFF, 8'hFF, 8'hFF);
         else if (seg == 6)
            set_registers(8'h03, 8'h04, 8'h01);
         else
            set_registers(8'($urandom_range(255)), 8'($urandom_range(255)),
                          8'($urandom_range(255)));
         if (seg == 0 || seg == 1)
            send_request(OP_INIT, 8'h5A, 1'b0, 6'd5);
         idle_pct = (seg == 2) ? 0 : 24;
         if (seg == 3)
            hold_request = 1'b1;
         for (int i = 0; i < SEGMENT_ITEMS; i++) begin
            if (seg == 4 && i == SEGMENT_ITEMS / 2)
               drain();
            send_random_request();
         end
      end

      drain();
      idle_pct = 24;
      repeat (END_CYCLES) @(posedge clock);
      if (pulse_book.mismatches == 0 && pulse_book.pending() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
